// ===== sv/md5_pkg.sv =====
// Package: MD5 constants, tables, round functions and shared types.
`default_nettype none
package md5_pkg;

  localparam int unsigned FifoDepth = 2;

  localparam logic [31:0] InitA = 32'h67452301;
  localparam logic [31:0] InitB = 32'hEFCDAB89;
  localparam logic [31:0] InitC = 32'h98BADCFE;
  localparam logic [31:0] InitD = 32'h10325476;

  localparam logic [7:0] PadByte = 8'h80;
  localparam logic [5:0] LenPos = 6'd56;

  // queued word: packed bytes, effective count, last flag
  typedef struct packed {
    logic [31:0] data;
    logic [2:0]  cnt;
    logic        last;
  } md5_word_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_ROUND,
    ST_FOLD,
    ST_PAD,
    ST_OUT
  } md5_state_t;

  function automatic logic [31:0] round_k(input logic [5:0] i);
    logic [31:0] k;
    case (i)
      6'd0: k = 32'hd76aa478;  6'd1: k = 32'he8c7b756;  6'd2: k = 32'h242070db;
      6'd3: k = 32'hc1bdceee;  6'd4: k = 32'hf57c0faf;  6'd5: k = 32'h4787c62a;
      6'd6: k = 32'ha8304613;  6'd7: k = 32'hfd469501;  6'd8: k = 32'h698098d8;
      6'd9: k = 32'h8b44f7af;  6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
      6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193; 6'd14: k = 32'ha679438e;
      6'd15: k = 32'h49b40821; 6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
      6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa; 6'd20: k = 32'hd62f105d;
      6'd21: k = 32'h02441453; 6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
      6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6; 6'd26: k = 32'hf4d50d87;
      6'd27: k = 32'h455a14ed; 6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
      6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a; 6'd32: k = 32'hfffa3942;
      6'd33: k = 32'h8771f681; 6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
      6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9; 6'd38: k = 32'hf6bb4b60;
      6'd39: k = 32'hbebfbc70; 6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
      6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05; 6'd44: k = 32'hd9d4d039;
      6'd45: k = 32'he6db99e5; 6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
      6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97; 6'd50: k = 32'hab9423a7;
      6'd51: k = 32'hfc93a039; 6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
      6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1; 6'd56: k = 32'h6fa87e4f;
      6'd57: k = 32'hfe2ce6e0; 6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
      6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235; 6'd62: k = 32'h2ad7d2bb;
      default: k = 32'heb86d391;
    endcase
    return k;
  endfunction

  function automatic logic [4:0] round_s(input logic [5:0] i);
    logic [4:0] s;
    case ({i[5:4], i[1:0]})
      4'd0: s = 5'd7;   4'd1: s = 5'd12;  4'd2: s = 5'd17;  4'd3: s = 5'd22;
      4'd4: s = 5'd5;   4'd5: s = 5'd9;   4'd6: s = 5'd14;  4'd7: s = 5'd20;
      4'd8: s = 5'd4;   4'd9: s = 5'd11;  4'd10: s = 5'd16; 4'd11: s = 5'd23;
      4'd12: s = 5'd6;  4'd13: s = 5'd10; 4'd14: s = 5'd15; default: s = 5'd21;
    endcase
    return s;
  endfunction

  // message word index used by round i
  function automatic logic [3:0] round_g(input logic [5:0] i);
    logic [3:0] g;
    case (i[5:4])
      2'd0: g = i[3:0];
      2'd1: g = 4'(5 * i[3:0] + 1);
      2'd2: g = 4'(3 * i[3:0] + 5);
      default: g = 4'(7 * i[3:0]);
    endcase
    return g;
  endfunction

endpackage
`default_nettype wire

// ===== sv/md5_if.sv =====
// Valid/ready channel interfaces for the MD5 engine.
`default_nettype none
interface md5_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] data_word;
  logic [2:0]  byte_count;
  logic        last_word;
  modport source (output valid, data_word, byte_count, last_word, input ready);
  modport sink (input valid, data_word, byte_count, last_word, output ready);
endinterface

interface md5_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] digest_low;
  logic [63:0] digest_high;
  modport source (output valid, digest_low, digest_high, input ready);
  modport sink (input valid, digest_low, digest_high, output ready);
endinterface
`default_nettype wire

// ===== sv/md5_ram.sv =====
// Generic single-port-write, single-read RAM with registered read.
`default_nettype none
module md5_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic      [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== sv/md5_front.sv =====
// Front end: accepts words, normalizes the byte count, feeds the queue.
`default_nettype none
module md5_front #(
  parameter int unsigned Depth = md5_pkg::FifoDepth
) (
  input  wire logic              clk,
  input  wire logic              rst,
  md5_in_if.sink                 in_ch,
  output logic                   q_valid,
  input  wire logic              q_pop,
  output md5_pkg::md5_word_t     q_word
);
  import md5_pkg::*;

  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;

  md5_word_t      slots [Depth];
  logic [AW-1:0]  wp;
  logic [AW-1:0]  rp;
  logic [AW:0]    used;
  md5_word_t      w_in;
  logic           push;

  always_comb begin
    w_in.data = in_ch.data_word;
    w_in.last = in_ch.last_word;
    w_in.cnt  = (!in_ch.last_word || in_ch.byte_count > 3'd4) ? 3'd4 : in_ch.byte_count;
  end

  assign in_ch.ready = (used != (AW+1)'(Depth));
  assign push    = in_ch.valid && in_ch.ready;
  assign q_valid = (used != '0);
  assign q_word  = slots[rp];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wp] <= w_in;
    end
    if (rst) begin
      wp   <= '0;
      rp   <= '0;
      used <= '0;
    end else begin
      if (push) begin
        wp <= (wp == AW'(Depth - 1)) ? '0 : AW'(wp + 1'b1);
      end
      if (q_pop) begin
        rp <= (rp == AW'(Depth - 1)) ? '0 : AW'(rp + 1'b1);
      end
      used <= (AW+1)'(used + (AW+1)'(push) - (AW+1)'(q_pop));
    end
  end
endmodule
`default_nettype wire

// ===== sv/md5_back.sv =====
// Back end: byte packing, padding, 64-round compression and digest output.
`default_nettype none
module md5_back (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              q_valid,
  output logic                   q_pop,
  input  wire md5_pkg::md5_word_t q_word,
  md5_out_if.source              out_ch
);
  import md5_pkg::*;

  md5_state_t  state, state_next;
  logic [31:0] ca, cb, cc, cd;        // chaining values
  logic [31:0] a, b, c, d;            // working variables
  logic [5:0]  fill;                  // bytes held in block
  logic [63:0] mbits;
  logic [63:0] total;                 // length latched at last word
  logic [31:0] wbuf;                  // word under assembly
  logic [31:0] pend;                  // bytes still to push
  logic [2:0]  pcnt;
  logic        plast;
  logic        padding;               // in padding phase
  logic        pad_first;             // 0x80 not yet pushed
  logic        len_blk;               // current block carries the length
  logic [5:0]  rnd;
  logic [63:0] out_lo, out_hi;
  logic        out_v;
  // set when the block going into compression carries the length bytes
  logic        done_len;

  logic        ram_we;
  logic [3:0]  ram_waddr, ram_raddr;
  logic [31:0] ram_rdata;

  // one byte push per cycle in LOAD/PAD
  logic [7:0]  pbyte;
  logic [31:0] wbuf_next_w;
  logic [5:0]  fill_inc;

  md5_ram #(.Width(32), .Depth(16)) u_ram (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(wbuf_next_w),
    .raddr(ram_raddr), .rdata(ram_rdata)
  );

  always_comb begin
    if (padding) begin
      if (pad_first) begin
        pbyte = PadByte;
      end else if (len_blk && (fill >= LenPos)) begin
        pbyte = total[8*(fill[2:0]) +: 8];
      end else begin
        pbyte = 8'h00;
      end
    end else begin
      pbyte = pend[7:0];
    end
    wbuf_next_w = wbuf;
    wbuf_next_w[8*fill[1:0] +: 8] = pbyte;
    fill_inc = 6'(fill + 1'b1);
  end

  logic [31:0] f, t, rot, sum;
  logic [4:0]  sh;
  always_comb begin
    case (rnd[5:4])
      2'd0: f = (b & c) | (~b & d);
      2'd1: f = (b & d) | (c & ~d);
      2'd2: f = b ^ c ^ d;
      default: f = c ^ (b | ~d);
    endcase
    t   = a + f + ram_rdata + round_k(rnd);
    sh  = round_s(rnd);
    rot = (t << sh) | (t >> (6'd32 - {1'b0, sh}));
    sum = b + rot;
  end

  logic byte_step;
  assign byte_step = (state == ST_PAD) || ((state == ST_LOAD) && (pcnt != 3'd0));
  assign ram_we    = byte_step && (fill[1:0] == 2'd3);
  assign ram_waddr = fill[5:2];
  // read address leads round counter by one (registered read)
  assign ram_raddr = (state == ST_ROUND) ? round_g(6'(rnd + 1'b1)) : round_g(6'd0);

  always_comb begin
    state_next = state;
    q_pop = 1'b0;
    case (state)
      ST_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          state_next = ST_LOAD;
        end
      end
      ST_LOAD: begin
        if (pcnt == 3'd0) begin
          state_next = plast ? ST_PAD : ST_IDLE;
        end else if (fill == 6'd63) begin
          state_next = ST_ROUND;
        end else if (pcnt == 3'd1) begin
          state_next = plast ? ST_PAD : ST_IDLE;
        end
      end
      ST_PAD: begin
        if (fill == 6'd63) begin
          state_next = ST_ROUND;
        end
      end
      ST_ROUND: begin
        if (rnd == 6'd63) begin
          state_next = ST_FOLD;
        end
      end
      ST_FOLD: begin
        if (padding && done_len) begin
          state_next = ST_OUT;
        end else if (padding) begin
          state_next = ST_PAD;
        end else if (pcnt != 3'd0) begin
          state_next = ST_LOAD;
        end else begin
          state_next = plast ? ST_PAD : ST_IDLE;
        end
      end
      ST_OUT: begin
        if (!out_v) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      ca <= InitA; cb <= InitB; cc <= InitC; cd <= InitD;
      fill <= '0; mbits <= '0; pcnt <= '0; plast <= 1'b0;
      padding <= 1'b0; pad_first <= 1'b0; done_len <= 1'b0; len_blk <= 1'b0;
      rnd <= '0; out_v <= 1'b0; pend <= '0;
    end else begin
      state <= state_next;
      if (out_v && out_ch.ready) begin
        out_v <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (q_valid) begin
            pend  <= q_word.data;
            pcnt  <= q_word.cnt;
            plast <= q_word.last;
            mbits <= mbits + {58'd0, q_word.cnt, 3'd0};
          end
        end
        ST_LOAD: begin
          if (pcnt != 3'd0) begin
            wbuf <= wbuf_next_w;
            fill <= fill_inc;
            pend <= {8'h00, pend[31:8]};
            pcnt <= 3'(pcnt - 1'b1);
          end
          if (state_next == ST_PAD) begin
            padding   <= 1'b1;
            pad_first <= 1'b1;
            total     <= mbits;
          end
          if (state_next == ST_ROUND) begin
            a <= ca; b <= cb; c <= cc; d <= cd; rnd <= '0;
          end
        end
        ST_PAD: begin
          wbuf <= wbuf_next_w;
          fill <= fill_inc;
          pad_first <= 1'b0;
          // 0x80 at byte 56 or later pushes the length into a second block
          if (pad_first) begin
            len_blk <= (fill < LenPos);
          end
          if (fill == 6'd63) begin
            a <= ca; b <= cb; c <= cc; d <= cd; rnd <= '0;
            done_len <= !pad_first && len_blk;
          end
        end
        ST_ROUND: begin
          a <= d; d <= c; c <= b; b <= sum;
          rnd <= 6'(rnd + 1'b1);
        end
        ST_FOLD: begin
          ca <= ca + a; cb <= cb + b; cc <= cc + c; cd <= cd + d;
          if (state_next == ST_PAD) begin
            done_len <= 1'b0;
            len_blk  <= 1'b1;
            // last word ended exactly on a block boundary
            if (!padding) begin
              padding   <= 1'b1;
              pad_first <= 1'b1;
              total     <= mbits;
            end
          end
          if (state_next == ST_OUT) begin
            out_lo <= {cb + b, ca + a};
            out_hi <= {cd + d, cc + c};
            out_v  <= 1'b1;
          end
        end
        ST_OUT: begin
          if (!out_v) begin
            ca <= InitA; cb <= InitB; cc <= InitC; cd <= InitD;
            fill <= '0; mbits <= '0; padding <= 1'b0; plast <= 1'b0;
            done_len <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  assign out_ch.valid       = out_v;
  assign out_ch.digest_low  = out_lo;
  assign out_ch.digest_high = out_hi;
endmodule
`default_nettype wire

// ===== sv/md5_message_digest.sv =====
// Top level of the streaming MD5 engine: front queue plus compression back end.
//
//   channel  | dir | payload
//   ---------+-----+------------------------------------------
//   in_ch    | in  | data_word[31:0], byte_count[2:0], last_word
//   out_ch   | out | digest_low[63:0], digest_high[63:0]
//
// Each word is dequeued in IDLE and its bytes are packed in LOAD.
// A full 64-byte block then runs the MD5 rounds (one MD5 round per cycle,
// message word from a 16x32 RAM read one round ahead) and a fold step.
// The last word adds padding at one byte per cycle, one or two blocks.
// rst is synchronous; the chaining values and counters reload on reset
// and again once the digest is taken. Until it is full, the front queue keeps
// taking words during compression; the back end stalls on an untaken digest.
`default_nettype none
module md5_message_digest #(
  parameter int unsigned QueueDepth = md5_pkg::FifoDepth
) (
  input wire logic clk,
  input wire logic rst,
  md5_in_if.sink   in_ch,
  md5_out_if.source out_ch
);
  import md5_pkg::*;

  logic      q_valid;
  logic      q_pop;
  md5_word_t q_word;

  md5_front #(.Depth(QueueDepth)) u_front (
    .clk(clk), .rst(rst), .in_ch(in_ch),
    .q_valid(q_valid), .q_pop(q_pop), .q_word(q_word)
  );

  md5_back u_back (
    .clk(clk), .rst(rst),
    .q_valid(q_valid), .q_pop(q_pop), .q_word(q_word),
    .out_ch(out_ch)
  );
endmodule
`default_nettype wire
